@@ rtl/lbm_pkg.sv @@
`timescale 1ns / 1ps
package lbm_pkg;

	localparam int LVL_W   = 16;
	localparam int SPD_W   = 20;
	localparam int TIME_W  = 32;
	localparam int MUL_W   = 28;

	localparam logic [SPD_W-1:0] SPEED_MAX    = 20'hFFFFF;
	localparam logic [LVL_W-1:0] FULL_SCALE   = 16'd16384;
	localparam logic [13:0]      FADE_MIN_REM = 14'd655;
	localparam logic [7:0]       DT_DEFAULT   = 8'd50;
	localparam logic [15:0]      DT_MAX       = 16'd200;
	localparam logic [6:0]       MAX_SEGS     = 7'd64;
	localparam logic [16:0]      MOTION_EPS   = 17'd16;
	localparam logic [MUL_W-1:0] HALF_MS      = 28'd500;
	// floor(x / 1000) = (x * RECIP_1000) >> 38 for x below 2^28
	localparam logic [28:0]      RECIP_1000   = 29'd274877907;

	localparam logic [2:0] REG_ATTACK     = 3'd0;
	localparam logic [2:0] REG_FALL_START = 3'd1;
	localparam logic [2:0] REG_FALL_ACC   = 3'd2;
	localparam logic [2:0] REG_HOLD       = 3'd3;
	localparam logic [2:0] REG_PK_START   = 3'd4;
	localparam logic [2:0] REG_PK_ACC     = 3'd5;
	localparam logic [2:0] REG_SEG_CNT    = 3'd6;
	localparam logic [2:0] REG_SMOOTH     = 3'd7;

	typedef struct packed {
		logic [15:0]      attack;
		logic [SPD_W-1:0] fall_start;
		logic [SPD_W-1:0] fall_acc;
		logic [15:0]      hold;
		logic [SPD_W-1:0] pk_start;
		logic [SPD_W-1:0] pk_acc;
		logic [6:0]       seg_cnt;
		logic             smooth;
	} lbm_cfg_t;

	typedef struct packed {
		logic [LVL_W-1:0]  shown;
		logic [SPD_W-1:0]  fspd;
		logic [LVL_W-1:0]  peak;
		logic [SPD_W-1:0]  pspd;
		logic [TIME_W-1:0] ptime;
	} lbm_entry_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_READ, ST_BAR, ST_DA, ST_MB, ST_DB, ST_BLAND,
		ST_PDA, ST_PMB, ST_PDB, ST_PLAND, ST_SEG, ST_OUT
	} lbm_state_t;

	typedef struct packed {
		logic latch;
		logic read;
		logic bar_setup;
		logic div;
		logic mul_speed;
		logic bar_land;
		logic peak_land;
		logic seg;
		logic out_load;
	} lbm_cmd_t;

	typedef struct packed {
		logic oor_in;
		logic pk_fall;
		logic out_free;
	} lbm_stat_t;

endpackage

@@ rtl/lbm_regs.sv @@
`timescale 1ns / 1ps
module lbm_regs import lbm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output lbm_cfg_t    cfg
);

	lbm_cfg_t cfg_q;
	logic     wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.attack     <= 16'd32768;
			cfg_q.fall_start <= 20'd16384;
			cfg_q.fall_acc   <= 20'd32768;
			cfg_q.hold       <= 16'd800;
			cfg_q.pk_start   <= 20'd8192;
			cfg_q.pk_acc     <= 20'd0;
			cfg_q.seg_cnt    <= 7'd20;
			cfg_q.smooth     <= 1'b1;
		end else if (wr_en) begin
			case (paddr[4:2])
				REG_ATTACK:     cfg_q.attack     <= pwdata[15:0];
				REG_FALL_START: cfg_q.fall_start <= pwdata[19:0];
				REG_FALL_ACC:   cfg_q.fall_acc   <= pwdata[19:0];
				REG_HOLD:       cfg_q.hold       <= pwdata[15:0];
				REG_PK_START:   cfg_q.pk_start   <= pwdata[19:0];
				REG_PK_ACC:     cfg_q.pk_acc     <= pwdata[19:0];
				REG_SEG_CNT:    cfg_q.seg_cnt    <= pwdata[6:0];
				REG_SMOOTH:     cfg_q.smooth     <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_ATTACK:     prdata = 32'(cfg_q.attack);
			REG_FALL_START: prdata = 32'(cfg_q.fall_start);
			REG_FALL_ACC:   prdata = 32'(cfg_q.fall_acc);
			REG_HOLD:       prdata = 32'(cfg_q.hold);
			REG_PK_START:   prdata = 32'(cfg_q.pk_start);
			REG_PK_ACC:     prdata = 32'(cfg_q.pk_acc);
			REG_SEG_CNT:    prdata = 32'(cfg_q.seg_cnt);
			REG_SMOOTH:     prdata = 32'(cfg_q.smooth);
			default:        prdata = 32'd0;
		endcase
	end

endmodule

@@ rtl/lbm_ctrl.sv @@
`timescale 1ns / 1ps
module lbm_ctrl import lbm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  lbm_stat_t stat,
	output lbm_cmd_t  cmd
);

	lbm_state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nx = stat.oor_in ? ST_OUT : ST_READ;
			end
			ST_READ:  state_nx = ST_BAR;
			ST_BAR:   state_nx = ST_DA;
			ST_DA:    state_nx = ST_MB;
			ST_MB:    state_nx = ST_DB;
			ST_DB:    state_nx = ST_BLAND;
			ST_BLAND: state_nx = stat.pk_fall ? ST_PDA : ST_SEG;
			ST_PDA:   state_nx = ST_PMB;
			ST_PMB:   state_nx = ST_PDB;
			ST_PDB:   state_nx = ST_PLAND;
			ST_PLAND: state_nx = ST_SEG;
			ST_SEG:   state_nx = ST_OUT;
			ST_OUT: begin
				if (stat.out_free) state_nx = ST_IDLE;
			end
			default:  state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.latch = in_valid;
			end
			ST_READ:  cmd.read      = 1'b1;
			ST_BAR:   cmd.bar_setup = 1'b1;
			ST_DA, ST_DB, ST_PDA, ST_PDB: cmd.div = 1'b1;
			ST_MB, ST_PMB: cmd.mul_speed = 1'b1;
			ST_BLAND: cmd.bar_land  = 1'b1;
			ST_PLAND: cmd.peak_land = 1'b1;
			ST_SEG:   cmd.seg       = 1'b1;
			ST_OUT:   cmd.out_load  = stat.out_free;
			default: ;
		endcase
	end

endmodule

@@ rtl/lbm_dp.sv @@
`timescale 1ns / 1ps
module lbm_dp import lbm_pkg::*; #(
	parameter int NUM_BANDS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lbm_cfg_t          cfg,
	input  lbm_cmd_t          cmd,
	output lbm_stat_t         stat,
	input  logic [4:0]        band_index,
	input  logic [15:0]       level_value,
	input  logic [31:0]       timestamp_ms,
	input  logic [15:0]       frame_interval_ms,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [4:0]        band_out,
	output logic [15:0]       shown_level,
	output logic [15:0]       held_peak,
	output logic [6:0]        lit_count,
	output logic [1:0]        top_zone,
	output logic [7:0]        top_fade,
	output logic [6:0]        peak_segment,
	output logic              peak_visible,
	output logic              motion_pending
);

	localparam int AW = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;

	lbm_entry_t mem [NUM_BANDS];
	logic [NUM_BANDS-1:0] vld_q;

	logic [4:0]        band_q;
	logic [15:0]       level_q;
	logic [31:0]       now_q;
	logic [7:0]        dt_q;
	logic [AW-1:0]     addr_q;
	logic              oor_q;
	lbm_entry_t        rd_q;
	logic              rdv_q;
	lbm_entry_t        ent;
	logic [31:0]       band_ext;

	logic              is_fall_q;
	logic [31:0]       rise_q;
	logic [SPD_W-1:0]  spd0_q, scl_q, spd_q;
	logic [MUL_W-1:0]  mulx_q;

	logic [LVL_W-1:0]  shown_n_q, peak_n_q;
	logic [SPD_W-1:0]  fspd_n_q, pspd_n_q;
	logic [TIME_W-1:0] ptime_n_q;
	logic              mot_q;
	logic [20:0]       prod_q;
	logic [8:0]        pseg_q;
	logic              motf_q;

	logic [56:0]       div_prod;
	logic [20:0]       s_sum;
	logic [SPD_W-1:0]  s_sat, fspd0, pspd0;
	logic [LVL_W-1:0]  rise_sh, shown_n;
	logic signed [21:0] np_b, np_p;
	logic              land_b, pk_latch, expired;
	logic [31:0]       elapsed;
	logic [6:0]        segs;
	logic [14:0]       clamped;
	logic [23:0]       pmul;
	logic signed [16:0] pk_gap;
	logic [6:0]        lit, top;
	logic [13:0]       rem;
	logic [21:0]       fmul;
	logic [7:0]        fade;
	logic [1:0]        zone;
	logic              vis;
	logic [6:0]        pseg_sat;
	logic              out_valid_q;

	assign band_ext = 32'(band_index);
	assign ent      = rdv_q ? rd_q : '0;
	assign out_valid = out_valid_q;

	assign stat.oor_in   = band_ext >= 32'(NUM_BANDS);
	assign stat.out_free = !out_valid_q || out_ready;

	// shared ballistic unit
	assign div_prod = 57'(mulx_q) * 57'(RECIP_1000);
	assign s_sum    = 21'(spd0_q) + 21'(scl_q);
	assign s_sat    = s_sum[20] ? SPEED_MAX : s_sum[19:0];
	assign fspd0    = (ent.fspd == '0) ? cfg.fall_start : ent.fspd;
	assign pspd0    = (ent.pspd == '0) ? cfg.pk_start : ent.pspd;

	// bar landing and peak decision
	assign rise_sh  = ent.shown + rise_q[31:16];
	assign np_b     = $signed({6'b0, ent.shown}) - $signed({2'b0, scl_q});
	assign land_b   = np_b <= $signed({6'b0, level_q});
	assign shown_n  = !is_fall_q ? rise_sh : (land_b ? level_q : np_b[15:0]);
	assign elapsed  = now_q - ent.ptime;
	assign expired  = elapsed > 32'(cfg.hold);
	assign pk_latch = shown_n >= ent.peak;
	assign stat.pk_fall = !pk_latch && expired;
	assign np_p     = $signed({6'b0, peak_n_q}) - $signed({2'b0, scl_q});

	// bar readout
	always_comb begin
		if (cfg.seg_cnt == 7'd0) segs = 7'd1;
		else if (cfg.seg_cnt > MAX_SEGS) segs = MAX_SEGS;
		else segs = cfg.seg_cnt;
	end
	assign clamped  = (shown_n_q > FULL_SCALE) ? FULL_SCALE[14:0] : shown_n_q[14:0];
	assign pmul     = 24'(peak_n_q) * 24'(segs) + 24'd8192;
	assign pk_gap   = $signed({1'b0, peak_n_q}) - $signed({1'b0, shown_n_q});
	assign lit      = prod_q[20:14];
	assign rem      = prod_q[13:0];
	assign fmul     = 22'(rem) * 22'd255 + 22'd8192;
	assign fade     = (cfg.smooth && lit < segs && rem > FADE_MIN_REM) ? fmul[21:14] : 8'd0;
	assign top      = (fade != 8'd0) ? lit : lit - 7'd1;
	always_comb begin
		if (fade == 8'd0 && lit == 7'd0) zone = 2'd0;
		else if (10'(top) * 10'd5 < 10'(segs) * 10'd3) zone = 2'd0;
		else if (12'(top) * 12'd20 < 12'(segs) * 12'd17) zone = 2'd1;
		else zone = 2'd2;
	end
	assign vis      = pseg_q > 9'(lit) && pseg_q <= 9'(segs);
	assign pseg_sat = (pseg_q > 9'(MAX_SEGS)) ? MAX_SEGS : pseg_q[6:0];

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			band_q  <= band_index;
			level_q <= level_value;
			now_q   <= timestamp_ms;
			addr_q  <= band_ext[AW-1:0];
			oor_q   <= stat.oor_in;
			if (frame_interval_ms == 16'd0 || frame_interval_ms > DT_MAX)
				dt_q <= DT_DEFAULT;
			else
				dt_q <= frame_interval_ms[7:0];
		end
		if (cmd.read) begin
			rd_q <= mem[addr_q];
		end
		if (cmd.bar_setup) begin
			is_fall_q <= level_q < ent.shown;
			rise_q    <= 32'(level_q - ent.shown) * 32'(cfg.attack);
			spd0_q    <= fspd0;
			mulx_q    <= 28'(cfg.fall_acc) * 28'(dt_q) + HALF_MS;
		end
		if (cmd.div) begin
			scl_q <= 20'(div_prod[56:38]);
		end
		if (cmd.mul_speed) begin
			spd_q  <= s_sat;
			mulx_q <= 28'(s_sat) * 28'(dt_q) + HALF_MS;
		end
		if (cmd.bar_land) begin
			shown_n_q <= shown_n;
			fspd_n_q  <= (!is_fall_q || land_b) ? '0 : spd_q;
			mot_q     <= !is_fall_q ? (17'(level_q) - 17'(rise_sh) > MOTION_EPS) : !land_b;
			peak_n_q  <= pk_latch ? shown_n : ent.peak;
			pspd_n_q  <= pk_latch ? '0 : ent.pspd;
			ptime_n_q <= pk_latch ? now_q : ent.ptime;
			spd0_q    <= pspd0;
			mulx_q    <= 28'(cfg.pk_acc) * 28'(dt_q) + HALF_MS;
		end
		if (cmd.peak_land) begin
			if (np_p < $signed({6'b0, shown_n_q})) begin
				peak_n_q <= shown_n_q;
				pspd_n_q <= '0;
			end else begin
				peak_n_q <= np_p[15:0];
				pspd_n_q <= spd_q;
			end
		end
		if (cmd.seg) begin
			mem[addr_q] <= '{shown: shown_n_q, fspd: fspd_n_q, peak: peak_n_q,
				pspd: pspd_n_q, ptime: ptime_n_q};
			prod_q <= 21'(clamped) * 21'(segs);
			pseg_q <= pmul[22:14];
			motf_q <= mot_q || (pk_gap > $signed(MOTION_EPS));
		end
		if (cmd.out_load) begin
			band_out <= band_q;
			if (oor_q) begin
				shown_level    <= '0;
				held_peak      <= '0;
				lit_count      <= '0;
				top_zone       <= '0;
				top_fade       <= '0;
				peak_segment   <= '0;
				peak_visible   <= 1'b0;
				motion_pending <= 1'b0;
			end else begin
				shown_level    <= shown_n_q;
				held_peak      <= peak_n_q;
				lit_count      <= lit;
				top_zone       <= zone;
				top_fade       <= fade;
				peak_segment   <= pseg_sat;
				peak_visible   <= vis;
				motion_pending <= motf_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			rdv_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.read) rdv_q <= vld_q[addr_q];
			if (cmd.seg) vld_q[addr_q] <= 1'b1;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

@@ rtl/led_bar_meter_ballistics_unit.sv @@
`timescale 1ns / 1ps
// led bar meter ballistics unit
// input channel (in_valid/in_ready) carries one band level per transaction with
// its frame time stamp and frame interval; output channel (out_valid/out_ready)
// returns one readout transaction per input: displayed level, peak, lit
// segments, top segment zone and fade, peak marker and motion flag
// one item is in flight at a time; in_ready is high only while idle
// after acceptance an item passes read, bar setup, then the shared fall unit
// (reciprocal divide by 1000, speed multiply, divide) and bar landing; when
// the peak falls the fall unit runs again before peak landing; then segment
// and output load follow; an out of range band goes straight to output load
// the result sits in an output register; a stalled receiver holds it and the
// block waits before loading the next result, no new input is taken meanwhile
// reset loads register defaults and clears the band valid bits (state reads 0)
// registers are to be written over the apb port by the user only while the
// block is idle; the block itself does not enforce it
module led_bar_meter_ballistics_unit import lbm_pkg::*; #(
	parameter int NUM_BANDS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [4:0]  band_index,
	input  logic [15:0] level_value,
	input  logic [31:0] timestamp_ms,
	input  logic [15:0] frame_interval_ms,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  band_out,
	output logic [15:0] shown_level,
	output logic [15:0] held_peak,
	output logic [6:0]  lit_count,
	output logic [1:0]  top_zone,
	output logic [7:0]  top_fade,
	output logic [6:0]  peak_segment,
	output logic        peak_visible,
	output logic        motion_pending
);

	lbm_cfg_t  cfg;
	lbm_cmd_t  cmd;
	lbm_stat_t stat;

	lbm_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .cfg
	);

	lbm_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .stat, .cmd
	);

	lbm_dp #(.NUM_BANDS(NUM_BANDS)) u_dp (
		.clk, .arst_n, .cfg, .cmd, .stat,
		.band_index, .level_value, .timestamp_ms, .frame_interval_ms,
		.out_ready, .out_valid, .band_out, .shown_level, .held_peak,
		.lit_count, .top_zone, .top_fade, .peak_segment, .peak_visible,
		.motion_pending
	);

endmodule

@@ rtl/lbm_checker.sv @@
`timescale 1ns / 1ps
module lbm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [4:0] band_out,
	input logic [6:0] lit_count,
	input logic [1:0] top_zone,
	input logic [6:0] peak_segment,
	input logic       peak_visible
);

	// held result stays valid and its band stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(band_out))
		else $error("output changed while stalled");

	// one item in flight
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> lit_count <= 7'd64 && peak_segment <= 7'd64 && top_zone != 2'd3)
		else $error("readout out of range");

	a_peak_vis: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && peak_visible |-> peak_segment > lit_count)
		else $error("visible peak not above bar");

endmodule

bind led_bar_meter_ballistics_unit lbm_checker u_lbm_checker (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .band_out,
	.lit_count, .top_zone, .peak_segment, .peak_visible
);

@@ tb/sv/led_bar_meter_ballistics_unit_test.sv @@
`timescale 1ns / 1ps
module led_bar_meter_ballistics_unit_test;
	import lbm_pkg::*;

	localparam int BANDS = 32;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 30;
	localparam int LONG_HOLD_CYCLES = 300;

	typedef struct {
		logic [4:0]  band;
		logic [15:0] shown;
		logic [15:0] peak;
		logic [6:0]  lit;
		logic [1:0]  zone;
		logic [7:0]  fade;
		logic [6:0]  pseg;
		logic        vis;
		logic        motion;
	} readout_t;

	typedef struct {
		logic [4:0]  band;
		logic [15:0] level;
		logic [31:0] stamp;
		logic [15:0] interval;
		bit          has_exp;
		readout_t    exp;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_ready;
	logic [4:0]  band_index;
	logic [15:0] level_value;
	logic [31:0] timestamp_ms;
	logic [15:0] frame_interval_ms;
	logic        out_valid;
	logic        out_ready;
	logic [4:0]  band_out;
	logic [15:0] shown_level;
	logic [15:0] held_peak;
	logic [6:0]  lit_count;
	logic [1:0]  top_zone;
	logic [7:0]  top_fade;
	logic [6:0]  peak_segment;
	logic        peak_visible;
	logic        motion_pending;

	led_bar_meter_ballistics_unit dut (.*);

	lbm_cfg_t    cfg;
	int unsigned bar_lvl [BANDS];
	int unsigned bar_spd [BANDS];
	int unsigned pk_lvl [BANDS];
	int unsigned pk_spd [BANDS];
	int unsigned pk_stamp [BANDS];
	int unsigned band_clock [BANDS];
	readout_t    readout_q [$];
	stim_row_t   dir_rows [$];
	int          fails = 0;
	int          cycles = 0;
	bit          quiet = 0;
	bit          hold_req = 0;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic int unsigned per_frame(longint unsigned rate, int unsigned dt);
		longint unsigned v;
		v = (rate * dt + 500) / 1000;
		return v > 64'hFFFFF ? 32'hFFFFF : 32'(v);
	endfunction

	function automatic longint drop_step(int unsigned pos, inout int unsigned spd,
			input int unsigned start, input int unsigned accel, input int unsigned dt);
		int unsigned s;
		s = spd == 0 ? start : spd;
		s = s + per_frame(accel, dt);
		if (s > 32'hFFFFF)
			s = 32'hFFFFF;
		spd = s;
		return longint'(pos) - longint'(per_frame(s, dt));
	endfunction

	function automatic readout_t ballistics(logic [4:0] b, logic [15:0] lvl, logic [31:0] now,
			logic [15:0] ivl);
		readout_t    r;
		int unsigned dt, shown, peak, segs, clamped, prod, lit, rem, fade, top, pseg;
		longint      np;
		bit          motion;
		motion = 0;
		dt = (ivl == 0 || ivl > 200) ? 50 : ivl;
		shown = bar_lvl[b];
		if (lvl >= shown) begin
			shown = shown + 32'((longint'(lvl - shown) * cfg.attack) >> 16);
			bar_spd[b] = 0;
			if (int'(lvl) - int'(shown) > 16)
				motion = 1;
		end else begin
			np = drop_step(shown, bar_spd[b], cfg.fall_start, cfg.fall_acc, dt);
			if (np <= longint'(lvl)) begin
				shown = lvl;
				bar_spd[b] = 0;
			end else begin
				shown = 32'(np);
				motion = 1;
			end
		end
		bar_lvl[b] = shown;
		peak = pk_lvl[b];
		if (shown >= peak) begin
			peak = shown;
			pk_stamp[b] = now;
			pk_spd[b] = 0;
		end else if (32'(now - pk_stamp[b]) > cfg.hold) begin
			np = drop_step(peak, pk_spd[b], cfg.pk_start, cfg.pk_acc, dt);
			if (np < longint'(shown)) begin
				peak = shown;
				pk_spd[b] = 0;
			end else begin
				peak = 32'(np);
			end
		end
		pk_lvl[b] = peak;
		if (int'(peak) - int'(shown) > 16)
			motion = 1;
		segs = cfg.seg_cnt == 0 ? 1 : (cfg.seg_cnt > 64 ? 64 : cfg.seg_cnt);
		clamped = shown > 16384 ? 16384 : shown;
		prod = clamped * segs;
		lit = prod >> 14;
		rem = prod & 16383;
		fade = 0;
		if (cfg.smooth && lit < segs && rem > 655)
			fade = (rem * 255 + 8192) >> 14;
		r.zone = 2'd0;
		if (fade != 0 || lit > 0) begin
			top = fade != 0 ? lit : lit - 1;
			if (5 * top < 3 * segs)
				r.zone = 2'd0;
			else if (20 * top < 17 * segs)
				r.zone = 2'd1;
			else
				r.zone = 2'd2;
		end
		pseg = (peak * segs + 8192) >> 14;
		r.band = b;
		r.shown = shown[15:0];
		r.peak = peak[15:0];
		r.lit = lit[6:0];
		r.fade = fade[7:0];
		r.vis = pseg > lit && pseg <= segs;
		r.pseg = pseg > 64 ? 7'd64 : pseg[6:0];
		r.motion = motion;
		return r;
	endfunction

	task automatic apb_write(logic [2:0] idx, logic [31:0] value);
		@(negedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	task automatic load_config(lbm_cfg_t c);
		apb_write(REG_ATTACK, 32'(c.attack));
		apb_write(REG_FALL_START, 32'(c.fall_start));
		apb_write(REG_FALL_ACC, 32'(c.fall_acc));
		apb_write(REG_HOLD, 32'(c.hold));
		apb_write(REG_PK_START, 32'(c.pk_start));
		apb_write(REG_PK_ACC, 32'(c.pk_acc));
		apb_write(REG_SEG_CNT, 32'(c.seg_cnt));
		apb_write(REG_SMOOTH, 32'(c.smooth));
		cfg = c;
	endtask

	task automatic drain();
		while (readout_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_level(stim_row_t row);
		readout_t r;
		if (!quiet && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 4)) begin
				@(negedge clk);
				in_valid <= 0;
			end
		@(negedge clk);
		in_valid <= 1;
		band_index <= row.band;
		level_value <= row.level;
		timestamp_ms <= row.stamp;
		frame_interval_ms <= row.interval;
		do
			@(posedge clk);
		while (!in_ready);
		r = ballistics(row.band, row.level, row.stamp, row.interval);
		readout_q = {readout_q, (row.has_exp ? row.exp : r)};
	endtask

	function automatic stim_row_t mk_row(logic [4:0] b, logic [15:0] lvl, logic [31:0] ts,
			logic [15:0] ivl);
		stim_row_t row;
		row.band = b;
		row.level = lvl;
		row.stamp = ts;
		row.interval = ivl;
		row.has_exp = 0;
		row.exp = '{default: 0};
		return row;
	endfunction

	function automatic stim_row_t random_row();
		stim_row_t   row;
		logic [4:0]  b;
		logic [15:0] lvl;
		logic [15:0] ivl;
		int          pick;
		if ($urandom_range(0, 6) == 0)
			return mk_row(5'($urandom), 16'($urandom), $urandom, 16'($urandom));
		b = 5'($urandom_range(0, BANDS - 1));
		pick = $urandom_range(0, 19);
		ivl = pick < 14 ? 16'($urandom_range(1, 200)) : (pick < 17 ? 16'd0 : 16'($urandom));
		band_clock[b] = band_clock[b] + $urandom_range(0, 300);
		pick = $urandom_range(0, 9);
		if (pick < 5)
			lvl = 16'($urandom_range(0, 16384));
		else if (pick < 7)
			lvl = 16'd0;
		else if (pick < 8)
			lvl = 16'($urandom);
		else
			lvl = 16'(bar_lvl[b] + $urandom_range(0, 64) - 32);
		return mk_row(b, lvl, band_clock[b], ivl);
	endfunction

	function automatic lbm_cfg_t random_cfg(logic [6:0] segs);
		lbm_cfg_t c;
		c.attack = 16'($urandom);
		c.fall_start = 20'($urandom_range(0, 40000));
		c.fall_acc = 20'($urandom_range(0, 200000));
		c.hold = 16'($urandom_range(0, 1500));
		c.pk_start = 20'($urandom_range(0, 40000));
		c.pk_acc = 20'($urandom_range(0, 100000));
		c.seg_cnt = segs;
		c.smooth = 1'($urandom);
		return c;
	endfunction

	// receiver side stalls, with one long hold on request
	initial begin
		int stall_left;
		int long_left;
		stall_left = 0;
		long_left = 0;
		out_ready = 0;
		forever begin
			@(negedge clk);
			if (hold_req && long_left == 0) begin
				long_left = LONG_HOLD_CYCLES;
				hold_req = 0;
			end
			if (long_left > 0) begin
				long_left--;
				out_ready <= 0;
			end else if (quiet) begin
				out_ready <= 1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 0;
			end else if ($urandom_range(0, 3) == 0) begin
				stall_left = $urandom_range(1, 4) - 1;
				out_ready <= 0;
			end else begin
				out_ready <= 1;
			end
		end
	end

	always @(posedge clk) begin
		readout_t e;
		if (arst_n && out_valid && out_ready) begin
			if (readout_q.size() == 0) begin
				$error("unexpected transaction on band %0d", band_out);
				fails++;
			end else begin
				e = readout_q.pop_front();
				if (band_out !== e.band) begin
					$error("band_out exp %0d got %0d", e.band, band_out);
					fails++;
				end
				if (shown_level !== e.shown) begin
					$error("shown_level exp %0d got %0d", e.shown, shown_level);
					fails++;
				end
				if (held_peak !== e.peak) begin
					$error("held_peak exp %0d got %0d", e.peak, held_peak);
					fails++;
				end
				if (lit_count !== e.lit) begin
					$error("lit_count exp %0d got %0d", e.lit, lit_count);
					fails++;
				end
				if (top_zone !== e.zone) begin
					$error("top_zone exp %0d got %0d", e.zone, top_zone);
					fails++;
				end
				if (top_fade !== e.fade) begin
					$error("top_fade exp %0d got %0d", e.fade, top_fade);
					fails++;
				end
				if (peak_segment !== e.pseg) begin
					$error("peak_segment exp %0d got %0d", e.pseg, peak_segment);
					fails++;
				end
				if (peak_visible !== e.vis) begin
					$error("peak_visible exp %0d got %0d", e.vis, peak_visible);
					fails++;
				end
				if (motion_pending !== e.motion) begin
					$error("motion_pending exp %0d got %0d", e.motion, motion_pending);
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("led_bar_meter_ballistics_unit regression: fail");
			$finish;
		end
	end

	initial begin
		stim_row_t row;
		lbm_cfg_t  c;
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		in_valid = 0;
		band_index = 0;
		level_value = 0;
		timestamp_ms = 0;
		frame_interval_ms = 0;
		cfg = '{attack: 16'd32768, fall_start: 20'd16384, fall_acc: 20'd32768, hold: 16'd800,
			pk_start: 20'd8192, pk_acc: 20'd0, seg_cnt: 7'd20, smooth: 1'b1};
		foreach (bar_lvl[i]) begin
			bar_lvl[i] = 0;
			bar_spd[i] = 0;
			pk_lvl[i] = 0;
			pk_spd[i] = 0;
			pk_stamp[i] = 0;
			band_clock[i] = $urandom;
		end
		repeat (12) @(negedge clk);
		arst_n = 1;

		// directed rows, register defaults
		row = mk_row(0, 0, 0, 0);
		row.has_exp = 1;
		row.exp = '{band: 0, default: 0};
		dir_rows = {dir_rows, row};
		row = mk_row(1, 16'hFFFF, 10, 16);
		row.has_exp = 1;
		row.exp = '{band: 1, shown: 32767, peak: 32767, lit: 20, zone: 2, fade: 0, pseg: 40,
			vis: 0, motion: 1};
		dir_rows = {dir_rows, row};
		dir_rows = {dir_rows, mk_row(1, 0, 60, 0)};
		dir_rows = {dir_rows, mk_row(1, 0, 260, 200)};
		dir_rows = {dir_rows, mk_row(1, 0, 461, 201)};
		dir_rows = {dir_rows, mk_row(1, 0, 2000, 16'hFFFF)};
		dir_rows = {dir_rows, mk_row(1, 0, 2001, 1)};
		dir_rows = {dir_rows, mk_row(1, 0, 2201, 200)};
		dir_rows = {dir_rows, mk_row(1, 0, 2401, 200)};
		dir_rows = {dir_rows, mk_row(1, 0, 2601, 200)};
		dir_rows = {dir_rows, mk_row(1, 0, 2801, 200)};
		dir_rows = {dir_rows, mk_row(2, 16384, 32'hFFFFFF00, 50)};
		dir_rows = {dir_rows, mk_row(2, 16384, 32'hFFFFFF40, 50)};
		dir_rows = {dir_rows, mk_row(2, 0, 32'h00000200, 100)};
		dir_rows = {dir_rows, mk_row(2, 0, 32'h00000400, 100)};
		dir_rows = {dir_rows, mk_row(2, 0, 32'h00000500, 100)};
		dir_rows = {dir_rows, mk_row(3, 9830, 100, 30)};
		dir_rows = {dir_rows, mk_row(3, 9830, 130, 30)};
		dir_rows = {dir_rows, mk_row(4, 13926, 100, 30)};
		dir_rows = {dir_rows, mk_row(4, 13926, 130, 30)};
		dir_rows = {dir_rows, mk_row(5, 900, 100, 30)};
		dir_rows = {dir_rows, mk_row(31, 16384, 32'hFFFFFFFF, 16'hFFFF)};
		dir_rows = {dir_rows, mk_row(31, 16384, 32'h7FFFFFFF, 16'h8000)};
		dir_rows = {dir_rows, mk_row(30, 16'h5555, 32'hAAAAAAAA, 16'h5555)};
		foreach (dir_rows[i])
			send_level(dir_rows[i]);
		@(negedge clk);
		in_valid <= 0;

		for (int ph = 0; ph < 6; ph++) begin
			drain();
			case (ph)
				0: c = '{default: 0};
				1: c = '{attack: 16'hFFFF, fall_start: 20'hFFFFF, fall_acc: 20'hFFFFF,
					hold: 16'hFFFF, pk_start: 20'hFFFFF, pk_acc: 20'hFFFFF, seg_cnt: 7'd127,
					smooth: 1'b1};
				2: c = '{attack: 16'd16384, fall_start: 20'd4000, fall_acc: 20'd20000,
					hold: 16'd100, pk_start: 20'd2000, pk_acc: 20'd5000, seg_cnt: 7'd64,
					smooth: 1'b1};
				3: c = random_cfg(7'($urandom_range(1, 64)));
				4: c = random_cfg(7'd1);
				default: c = random_cfg(7'd65);
			endcase
			load_config(c);
			if (ph == 2)
				hold_req = 1;
			if (ph == 5)
				quiet = 1;
			repeat (215)
				send_level(random_row());
			@(negedge clk);
			in_valid <= 0;
		end

		drain();
		if (fails == 0)
			$display("led_bar_meter_ballistics_unit regression: pass");
		else
			$display("led_bar_meter_ballistics_unit regression: fail");
		$finish;
	end

endmodule
